// ===== rtl/asr_pkg.sv =====
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants of the oversampling serial receiver: phase
// codes, parity modes, register map, configuration and result bundles.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int SpbW   = 20;   // samples per bit, 8 fraction bits
  localparam int CntW   = 20;   // sample counter
  localparam int MaxRes = 4;    // results one sample can cause
  localparam int ResCntW = $clog2(MaxRes + 1);
  localparam int AddrW  = 5;    // 7 registers at 4-byte spacing
  localparam int DataW  = 32;

  // receiver phases
  localparam logic [2:0] PH_WAIT_IDLE   = 3'd0;
  localparam logic [2:0] PH_CHECK_IDLE  = 3'd1;
  localparam logic [2:0] PH_IDLE        = 3'd2;
  localparam logic [2:0] PH_CHECK_START = 3'd3;
  localparam logic [2:0] PH_DATA        = 3'd4;
  localparam logic [2:0] PH_PARITY      = 3'd5;
  localparam logic [2:0] PH_STOP        = 3'd6;

  // parity modes
  localparam logic [2:0] PAR_NONE  = 3'd0;
  localparam logic [2:0] PAR_ODD   = 3'd1;
  localparam logic [2:0] PAR_EVEN  = 3'd2;
  localparam logic [2:0] PAR_MARK  = 3'd3;
  localparam logic [2:0] PAR_SPACE = 3'd4;

  // register indexes
  localparam logic [2:0] REG_SPB       = 3'd0;
  localparam logic [2:0] REG_DATA_BITS = 3'd1;
  localparam logic [2:0] REG_PARITY    = 3'd2;
  localparam logic [2:0] REG_FRAME_EN  = 3'd3;
  localparam logic [2:0] REG_ESCAPE    = 3'd4;
  localparam logic [2:0] REG_START_MK  = 3'd5;
  localparam logic [2:0] REG_END_MK    = 3'd6;

  // reset values
  localparam logic [SpbW-1:0] RST_SPB       = 20'd25600;
  localparam logic [3:0]      RST_DATA_BITS = 4'd5;
  localparam logic [7:0]      RST_ESCAPE    = 8'd27;
  localparam logic [7:0]      RST_START_MK  = 8'd2;
  localparam logic [7:0]      RST_END_MK    = 8'd3;

  typedef struct packed {
    logic [SpbW-1:0] spb;
    logic [3:0]      data_bits;
    logic [2:0]      parity;
    logic            frame_en;
    logic [7:0]      escape;
    logic [7:0]      start_mk;
    logic [7:0]      end_mk;
  } cfg_t;

  typedef struct packed {
    logic                   load;
    logic [ResCntW-1:0]     cnt;
    logic [MaxRes-1:0][7:0] bytes;
  } res_t;

endpackage

// ===== rtl/asr_cfg.sv =====
// ----------------------------------------------------------------------------
// asr_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module asr_cfg import asr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spb       <= RST_SPB;
      cfg_r.data_bits <= RST_DATA_BITS;
      cfg_r.parity    <= PAR_NONE;
      cfg_r.frame_en  <= 1'b0;
      cfg_r.escape    <= RST_ESCAPE;
      cfg_r.start_mk  <= RST_START_MK;
      cfg_r.end_mk    <= RST_END_MK;
    end else if (wr_en) begin
      case (idx)
        REG_SPB:       cfg_r.spb       <= pwdata[SpbW-1:0];
        REG_DATA_BITS: cfg_r.data_bits <= pwdata[3:0];
        REG_PARITY:    cfg_r.parity    <= pwdata[2:0];
        REG_FRAME_EN:  cfg_r.frame_en  <= pwdata[0];
        REG_ESCAPE:    cfg_r.escape    <= pwdata[7:0];
        REG_START_MK:  cfg_r.start_mk  <= pwdata[7:0];
        REG_END_MK:    cfg_r.end_mk    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPB:       prdata = {{(DataW-SpbW){1'b0}}, cfg_r.spb};
      REG_DATA_BITS: prdata = {28'd0, cfg_r.data_bits};
      REG_PARITY:    prdata = {29'd0, cfg_r.parity};
      REG_FRAME_EN:  prdata = {31'd0, cfg_r.frame_en};
      REG_ESCAPE:    prdata = {24'd0, cfg_r.escape};
      REG_START_MK:  prdata = {24'd0, cfg_r.start_mk};
      REG_END_MK:    prdata = {24'd0, cfg_r.end_mk};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/asr_core.sv =====
// ----------------------------------------------------------------------------
// asr_core
// Sample register, receiver phase logic and carrier framing; builds the
// result bundle of one sample in a single pass.
// ----------------------------------------------------------------------------
module asr_core import asr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_line_level,
  input  logic in_carrier_present,
  input  cfg_t cfg,
  input  logic can_load,
  output res_t res
);

  logic            in_v_r;
  logic            line_r;
  logic            carrier_r;
  logic [2:0]      phase_r, phase_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [3:0]      bi_r, bi_nxt;
  logic [3:0]      ones_r, ones_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            cf_r, cf_nxt;
  logic            pe_r, pe_nxt;

  logic            consume;
  logic [3:0]      nbits;
  logic [3:0]      bi_inc;
  logic [CntW-1:0] cnt_inc;
  logic [28:0]     cnt_x;
  logic [5:0]      k;
  logic [25:0]     prod;
  logic            half_ok;
  logic            centre_ok;
  logic            stop_good;
  logic [ResCntW-1:0]     n;
  logic [MaxRes-1:0][7:0] bytes;

  assign consume  = in_v_r & can_load;
  assign in_ready = ~in_v_r | consume;

  // sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      line_r    <= in_line_level;
      carrier_r <= in_carrier_present;
    end
  end

  // timing checks on the incremented count
  always_comb begin
    if (cfg.data_bits == 4'd0) begin
      nbits = 4'd1;
    end else if (cfg.data_bits > 4'd8) begin
      nbits = 4'd8;
    end else begin
      nbits = cfg.data_bits;
    end
    cnt_inc   = (cnt_r == {CntW{1'b1}}) ? cnt_r : cnt_r + 1'b1;
    cnt_x     = {cnt_inc, 9'd0};
    k         = {1'b0, bi_r, 1'b1} + 6'd2;
    prod      = {20'd0, k} * {6'd0, cfg.spb};
    half_ok   = cnt_x >= {9'd0, cfg.spb};
    centre_ok = cnt_x >= {3'd0, prod};
    bi_inc    = bi_r + 4'd1;
  end

  // receiver phase logic
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bi_nxt    = bi_r;
    ones_nxt  = ones_r;
    shift_nxt = shift_r;
    stop_good = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (!line_r) begin
          phase_nxt = PH_CHECK_START;
          cnt_nxt   = '0;
        end
      end
      PH_CHECK_START: begin
        cnt_nxt = cnt_inc;
        if (!line_r) begin
          if (half_ok) begin
            phase_nxt = PH_DATA;
            bi_nxt    = '0;
            ones_nxt  = '0;
            shift_nxt = '0;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DATA: begin
        cnt_nxt = cnt_inc;
        if (centre_ok) begin
          if (line_r && !bi_r[3]) begin
            shift_nxt[bi_r[2:0]] = 1'b1;
            ones_nxt = ones_r + 4'd1;
          end
          bi_nxt = bi_inc;
          if (bi_inc >= nbits) begin
            phase_nxt = (cfg.parity == PAR_NONE) ? PH_STOP : PH_PARITY;
          end
        end
      end
      PH_PARITY: begin
        cnt_nxt = cnt_inc;
        if (centre_ok) begin
          bi_nxt = bi_inc;
          case (cfg.parity)
            PAR_ODD: begin
              phase_nxt = (line_r != ones_r[0]) ? PH_STOP
                        : (line_r ? PH_IDLE : PH_WAIT_IDLE);
            end
            PAR_EVEN: begin
              phase_nxt = (line_r == ones_r[0]) ? PH_STOP
                        : (line_r ? PH_IDLE : PH_WAIT_IDLE);
            end
            PAR_MARK: begin
              phase_nxt = line_r ? PH_STOP : PH_WAIT_IDLE;
            end
            PAR_SPACE: begin
              phase_nxt = line_r ? PH_IDLE : PH_STOP;
            end
            default: begin
              phase_nxt = PH_STOP;
            end
          endcase
        end
      end
      PH_STOP: begin
        cnt_nxt = cnt_inc;
        if (centre_ok) begin
          bi_nxt    = bi_inc;
          stop_good = line_r;
          phase_nxt = line_r ? PH_IDLE : PH_WAIT_IDLE;
        end
      end
      PH_CHECK_IDLE: begin
        cnt_nxt = cnt_inc;
        if (line_r) begin
          if (half_ok) begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          phase_nxt = PH_WAIT_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_WAIT_IDLE;
        if (line_r) begin
          phase_nxt = PH_CHECK_IDLE;
          cnt_nxt   = '0;
        end
      end
    endcase
  end

  // carrier framing and result packing
  always_comb begin
    n      = '0;
    bytes  = '0;
    cf_nxt = cfg.frame_en ? carrier_r : 1'b1;
    if (cfg.frame_en) begin
      if (pe_r) begin
        bytes[n[1:0]] = cfg.escape;
        n = n + 1'b1;
      end
      if (carrier_r != cf_r) begin
        bytes[n[1:0]] = cfg.escape;
        n = n + 1'b1;
        bytes[n[1:0]] = carrier_r ? cfg.start_mk : cfg.end_mk;
        n = n + 1'b1;
      end
    end
    if (stop_good && cf_nxt) begin
      bytes[n[1:0]] = shift_r;
      n = n + 1'b1;
    end
    pe_nxt = stop_good & cf_nxt & (shift_r == cfg.escape);
  end

  assign res.load  = consume;
  assign res.cnt   = n;
  assign res.bytes = bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_IDLE;
      cnt_r   <= '0;
      bi_r    <= '0;
      ones_r  <= '0;
      shift_r <= '0;
      cf_r    <= 1'b0;
      pe_r    <= 1'b0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bi_r    <= bi_nxt;
      ones_r  <= ones_nxt;
      shift_r <= shift_nxt;
      cf_r    <= cf_nxt;
      pe_r    <= pe_nxt;
    end
  end

endmodule

// ===== rtl/asr_outq.sv =====
// ----------------------------------------------------------------------------
// asr_outq
// Result register: holds the bytes of one sample and hands them out one beat
// at a time, flagging the final one.
// ----------------------------------------------------------------------------
module asr_outq import asr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [MaxRes-1:0][7:0] q_r;
  logic [ResCntW-1:0]     rem_r;
  logic                   beat;

  assign out_valid = rem_r != '0;
  assign out_byte  = q_r[0];
  assign out_last  = rem_r == ResCntW'(1);
  assign beat      = out_valid & out_ready;
  assign can_load  = (rem_r == '0) | (out_last & out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (res.load) begin
      rem_r <= res.cnt;
    end else if (beat) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      q_r <= res.bytes;
    end else if (beat) begin
      q_r <= {8'h00, q_r[MaxRes-1:1]};
    end
  end

endmodule

// ===== rtl/async_serial_receiver.sv =====
// ----------------------------------------------------------------------------
// async_serial_receiver
// Oversampling start/stop receiver with optional carrier framing.
// ----------------------------------------------------------------------------
// usage:
//   in channel takes one demodulated sample per beat: line level (1 = mark)
//   and the carrier-detect bit. out channel gives the bytes the sample
//   causes (pending escape, escape plus start/end marker on a carrier edge,
//   then a received data byte), out_last marking the final one of a sample.
//   most samples cause no byte at all.
//   registers sit on an APB-style port at byte address 4*i, pready tied high;
//   write them only while the block is idle.
// timing:
//   a sample sits in the sample register and is decoded in one pass into the
//   result register, from which its first byte shows. one sample per cycle
//   is sustained while each sample causes at most one byte and out_ready
//   stays high; a sample with more bytes holds the next one until the result
//   register has drained, one beat per cycle while out_ready is high.
// reset (rst_n low, synchronous): registers take their defaults, receiver
//   waits for idle line, carrier flag and pending escape clear, no bytes held.
// stall: with out_ready low the result register holds its bytes, the sample
//   register still takes one more sample, then in_ready drops.
// ----------------------------------------------------------------------------
module async_serial_receiver import asr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_line_level,
  input  logic             in_carrier_present,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  res_t res;
  logic can_load;

  // register file
  asr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sample register, phase logic, framing
  asr_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_line_level      (in_line_level),
    .in_carrier_present (in_carrier_present),
    .cfg                (cfg),
    .can_load           (can_load),
    .res                (res)
  );

  // result register, one byte per beat
  asr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== rtl/asr_chk.sv =====
// ----------------------------------------------------------------------------
// asr_chk
// Port-level checks of the serial receiver, bound to the top level.
// ----------------------------------------------------------------------------
module asr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("out beat changed while stalled");

  // bytes of one sample come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a sample's bytes");

  // empty result register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with nothing to send");

  // reset drops any held bytes
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("bytes left after reset");

endmodule

bind async_serial_receiver asr_chk u_asr_chk (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oversampling serial receiver. Builds sample
// streams of whole start/stop frames (good, bad parity, broken stop, start
// glitches) with random content and carrier activity, mirrors the receiver
// and carrier framing in a bench-side decoder, and compares every out beat
// with the decoded bytes in order. Registers are rewritten between passes.
// ----------------------------------------------------------------------------
module tb_top;
  import asr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // parity codes the package leaves unnamed
  localparam logic [2:0] PAR_SPARE6  = 3'd6;
  localparam logic [2:0] PAR_SPARE7  = 3'd7;

  localparam int QuietCycles = 8;   // sample reg + result reg, with margin

  typedef struct packed {
    logic line;
    logic carrier;
  } line_sample_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } rx_beat_t;

  // dut ports
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_line_level = 1'b1;
  logic             in_carrier_present = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  async_serial_receiver DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_line_level      (in_line_level),
    .in_carrier_present (in_carrier_present),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // bench copy of the registers, reset values
  cfg_t shadow_cfg = '{spb: RST_SPB, data_bits: RST_DATA_BITS, parity: PAR_NONE,
                       frame_en: 1'b0, escape: RST_ESCAPE, start_mk: RST_START_MK,
                       end_mk: RST_END_MK};

  // bench copy of the receiver state
  logic [2:0]      rx_state = PH_WAIT_IDLE;
  logic [CntW-1:0] sample_cnt = '0;
  logic [3:0]      bit_pos = '0;
  logic [3:0]      ones_seen = '0;
  logic [7:0]      shift_reg = '0;
  logic            carrier_up = 1'b0;
  logic            esc_owed = 1'b0;
  logic            start_owed = 1'b0;
  logic            end_owed = 1'b0;

  line_sample_t samples_to_send[$];
  rx_beat_t     rx_bytes_due[$];
  int           mismatch_count = 0;

  // pacing, changed per pass
  int         send_gap_max = 0;
  logic [7:0] ready_pattern = 8'hFF;
  int         carrier_churn = 0;     // 1-in-n chance of a carrier flip per sample
  logic       carrier_now = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  logic [2:0] ready_tick = '0;

  // ---------------------------------------------------------------------------
  // receiver decode
  // ---------------------------------------------------------------------------

  // out-of-range data bit counts fold into 1..8
  function automatic int eff_data_bits(input logic [3:0] db);
    if (db == 4'd0) return 1;
    if (db > 4'd8) return 8;
    return int'(db);
  endfunction

  function automatic logic half_bit_due();
    return ({44'd0, sample_cnt} << 9) >= {44'd0, shadow_cfg.spb};
  endfunction

  // bit centre k lies at (2k + 3) half bits after the start edge
  function automatic logic centre_due();
    logic [63:0] halves;
    halves = {59'd0, bit_pos, 1'b0} + 64'd3;
    return ({44'd0, sample_cnt} << 9) >= halves * {44'd0, shadow_cfg.spb};
  endfunction

  task automatic bump_count();
    if (sample_cnt != '1) sample_cnt = sample_cnt + 1'b1;
  endtask

  // one accepted sample: queue the bytes it causes, framing bytes first
  task automatic receive_sample(input logic mark, input logic carrier);
    logic [7:0] got[$];
    rx_beat_t   beat;
    int         nbits;
    int         g;
    int         n;
    logic       busy;
    logic       pass;
    nbits = eff_data_bits(shadow_cfg.data_bits);

    // carrier framing: drain owed bytes, then react to a carrier edge
    if (shadow_cfg.frame_en) begin
      busy = 1'b1;
      for (g = 0; g < 8 && busy; g++) begin
        if (esc_owed) begin
          got.push_back(shadow_cfg.escape);
          esc_owed = 1'b0;
        end else if (start_owed) begin
          got.push_back(shadow_cfg.start_mk);
          start_owed = 1'b0;
        end else if (end_owed) begin
          got.push_back(shadow_cfg.end_mk);
          end_owed = 1'b0;
        end else if (!carrier_up && carrier) begin
          carrier_up = 1'b1;
          got.push_back(shadow_cfg.escape);
          start_owed = 1'b1;
        end else if (carrier_up && !carrier) begin
          carrier_up = 1'b0;
          got.push_back(shadow_cfg.escape);
          end_owed = 1'b1;
        end else begin
          busy = 1'b0;
        end
      end
    end else begin
      // framing off: carrier taken as present, nothing owed
      carrier_up = 1'b1;
      esc_owed = 1'b0;
      start_owed = 1'b0;
      end_owed = 1'b0;
    end

    case (rx_state)
      PH_IDLE: begin
        if (!mark) begin
          rx_state = PH_CHECK_START;
          sample_cnt = '0;
        end
      end
      PH_CHECK_START: begin
        bump_count();
        if (!mark) begin
          if (half_bit_due()) begin
            rx_state = PH_DATA;
            bit_pos = '0;
            ones_seen = '0;
            shift_reg = '0;
          end
        end else begin
          rx_state = PH_IDLE;
        end
      end
      PH_DATA: begin
        bump_count();
        if (centre_due()) begin
          if (mark && bit_pos < 4'd8) begin
            shift_reg[bit_pos[2:0]] = 1'b1;
            ones_seen = ones_seen + 1'b1;
          end
          bit_pos = bit_pos + 1'b1;
          if (int'(bit_pos) >= nbits)
            rx_state = (shadow_cfg.parity == PAR_NONE) ? PH_STOP : PH_PARITY;
        end
      end
      PH_PARITY: begin
        bump_count();
        if (centre_due()) begin
          bit_pos = bit_pos + 1'b1;
          case (shadow_cfg.parity)
            PAR_ODD:   pass = (mark != ones_seen[0]);
            PAR_EVEN:  pass = (mark == ones_seen[0]);
            PAR_MARK:  pass = mark;
            PAR_SPACE: pass = !mark;
            default:   pass = 1'b1;   // slot consumed unchecked
          endcase
          if (pass) rx_state = PH_STOP;
          else rx_state = mark ? PH_IDLE : PH_WAIT_IDLE;
        end
      end
      PH_STOP: begin
        bump_count();
        if (centre_due()) begin
          bit_pos = bit_pos + 1'b1;
          if (mark) begin
            if (carrier_up) begin
              got.push_back(shift_reg);
              if (shift_reg == shadow_cfg.escape) esc_owed = 1'b1;
            end
            rx_state = PH_IDLE;
          end else begin
            rx_state = PH_WAIT_IDLE;
          end
        end
      end
      PH_CHECK_IDLE: begin
        bump_count();
        if (mark) begin
          if (half_bit_due()) rx_state = PH_IDLE;
        end else begin
          rx_state = PH_WAIT_IDLE;
        end
      end
      default: begin
        // wait for idle, spare code folds in here
        rx_state = PH_WAIT_IDLE;
        if (mark) begin
          rx_state = PH_CHECK_IDLE;
          sample_cnt = '0;
        end
      end
    endcase

    n = (got.size() > MaxRes) ? MaxRes : got.size();
    for (g = 0; g < n; g++) begin
      beat.val = got[g];
      beat.last = (g == n - 1);
      rx_bytes_due.push_back(beat);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: in channel, bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    line_sample_t s;
    logic         nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) receive_sample(in_line_level, in_carrier_present);
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (samples_to_send.size() != 0) begin
          s = samples_to_send.pop_front();
          nxt_valid = 1'b1;
          in_line_level <= s.line;
          in_carrier_present <= s.carrier;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
          end else begin
            burst_left--;
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: out channel, ready follows a rotating pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_bytes
    rx_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_tick <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (rx_bytes_due.size() == 0) begin
          $display("%0t: unexpected beat: expected none, got byte %02h last %0b",
                   $time, out_byte, out_last);
          mismatch_count++;
        end else begin
          want = rx_bytes_due.pop_front();
          if (out_byte !== want.val) begin
            $display("%0t: byte mismatch: expected %02h, got %02h",
                     $time, want.val, out_byte);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, want.last, out_last);
            mismatch_count++;
          end
        end
      end
      ready_tick <= ready_tick + 1'b1;
      out_ready <= ready_pattern[ready_tick];
    end
  end

  // ---------------------------------------------------------------------------
  // register access and stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPB:       shadow_cfg.spb = val[SpbW-1:0];
      REG_DATA_BITS: shadow_cfg.data_bits = val[3:0];
      REG_PARITY:    shadow_cfg.parity = val[2:0];
      REG_FRAME_EN:  shadow_cfg.frame_en = val[0];
      REG_ESCAPE:    shadow_cfg.escape = val[7:0];
      REG_START_MK:  shadow_cfg.start_mk = val[7:0];
      REG_END_MK:    shadow_cfg.end_mk = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [SpbW-1:0] spb, input logic [3:0] db,
                              input logic [2:0] par, input logic fen,
                              input logic [7:0] esc, input logic [7:0] smk,
                              input logic [7:0] emk);
    write_reg(REG_SPB, DataW'(spb));
    write_reg(REG_DATA_BITS, DataW'(db));
    write_reg(REG_PARITY, DataW'(par));
    write_reg(REG_FRAME_EN, DataW'(fen));
    write_reg(REG_ESCAPE, DataW'(esc));
    write_reg(REG_START_MK, DataW'(smk));
    write_reg(REG_END_MK, DataW'(emk));
  endtask

  // block idle: nothing queued, nothing owed, pipeline flushed
  task automatic wait_quiet();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || rx_bytes_due.size() != 0);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic set_pacing();
    case ($urandom_range(0, 3))
      0: begin send_gap_max = 0; ready_pattern = 8'hFF; end
      1: begin send_gap_max = 2; ready_pattern = 8'($urandom) | 8'h01; end
      2: begin send_gap_max = 6; ready_pattern = 8'h11; end
      default: begin send_gap_max = 0; ready_pattern = 8'($urandom) | 8'h80; end
    endcase
  endtask

  task automatic add_sample(input logic line);
    line_sample_t s;
    if (carrier_churn != 0 && $urandom_range(1, carrier_churn) == 1)
      carrier_now = !carrier_now;
    s.line = line;
    s.carrier = carrier_now;
    samples_to_send.push_back(s);
  endtask

  task automatic add_idle(input int n);
    repeat (n) add_sample(1'b1);
  endtask

  // waveform at the current bit length: start, data lsb first, parity, stop
  task automatic add_frame(input logic [7:0] d, input int nb, input logic has_par,
                           input logic pbit, input logic stop);
    logic [11:0]     bits;
    int              i;
    int              total;
    longint unsigned j;
    bits = '0;
    for (i = 0; i < nb; i++) bits[1 + i] = d[i];
    total = nb + 1;
    if (has_par) begin
      bits[total] = pbit;
      total++;
    end
    bits[total] = stop;
    total++;
    for (j = 0; (j * 256) / shadow_cfg.spb < total; j++)
      add_sample(bits[(j * 256) / shadow_cfg.spb]);
  endtask

  // parity bit that the current mode accepts
  function automatic logic parity_slot(input logic [7:0] d);
    case (shadow_cfg.parity)
      PAR_ODD:   return !(^d);
      PAR_EVEN:  return ^d;
      PAR_MARK:  return 1'b1;
      PAR_SPACE: return 1'b0;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sequence of passes
  // ---------------------------------------------------------------------------
  initial begin : run_passes
    int         pm;
    logic [7:0] d;
    logic       pbit;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values but the bit length: 5 data bits, no parity, framing off
    write_reg(REG_SPB, DataW'(20'd512));
    add_idle(3);
    add_frame(8'h15, 5, 1'b0, 1'b0, 1'b1);
    add_idle(2);
    wait_quiet();

    // two-sample bit, 8 bits: glitch, broken stop, escape w/o framing
    send_gap_max = 3;
    ready_pattern = 8'hB5;
    apply_config(20'd512, 4'd8, PAR_NONE, 1'b0, 8'hC3, RST_START_MK, RST_END_MK);
    add_idle(2);
    add_sample(1'b0);
    add_idle(2);
    add_frame(8'h3C, 8, 1'b0, 1'b0, 1'b0);
    add_idle(2);
    add_frame(8'hC3, 8, 1'b0, 1'b0, 1'b1);
    add_idle(2);
    wait_quiet();

    // every parity code but none, fractional bit length, folded data bit count
    send_gap_max = 0;
    ready_pattern = 8'hFF;
    for (pm = int'(PAR_ODD); pm <= int'(PAR_SPARE7); pm++) begin
      apply_config(20'd640, 4'd0, 3'(pm), 1'b0, RST_ESCAPE, RST_START_MK, RST_END_MK);
      d = 8'($urandom) & 8'h01;
      pbit = parity_slot(d);
      if (pm[0] == 1'b0) pbit = !pbit;
      add_frame(d, 1, 1'b1, pbit, 1'b1);
      add_idle(2);
      wait_quiet();
    end

    // carrier framing: enabled with carrier absent, frames without carrier,
    // start/end markers, escape doubling, carrier edge on a frame start
    send_gap_max = 2;
    ready_pattern = 8'h11;
    carrier_churn = 0;
    carrier_now = 1'b0;
    apply_config(20'd512, 4'd3, PAR_NONE, 1'b1, 8'h05, 8'h00, 8'hFF);
    add_idle(2);
    add_frame(8'h02, 3, 1'b0, 1'b0, 1'b1);
    carrier_now = 1'b1;
    add_idle(2);
    add_frame(8'h05, 3, 1'b0, 1'b0, 1'b1);
    add_idle(2);
    carrier_now = 1'b0;
    add_idle(2);
    carrier_now = 1'b1;
    add_frame(8'h05, 3, 1'b0, 1'b0, 1'b1);
    add_idle(2);
    wait_quiet();

    // zero bit length: every time check passes at once, busy carrier
    set_pacing();
    apply_config(20'd0, 4'd0, PAR_ODD, 1'b1, 8'h00, 8'hFF, 8'h00);
    carrier_churn = 4;
    repeat (20) add_sample(1'($urandom_range(0, 1)));
    wait_quiet();

    // longest bit: the count of a held start stays short of the half bit
    set_pacing();
    apply_config(20'hFFFFF, 4'd15, PAR_SPARE6, 1'b0, 8'hFF, 8'h00, 8'hFF);
    carrier_churn = 16;
    add_idle(4);
    repeat (8) add_sample(1'b0);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("async_serial_receiver regression: pass");
    end else begin
      $display("async_serial_receiver regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("async_serial_receiver regression: fail");
    $finish;
  end

endmodule

// ===== async_serial_receiver.f =====
rtl/asr_pkg.sv
rtl/asr_cfg.sv
rtl/asr_core.sv
rtl/asr_outq.sv
rtl/async_serial_receiver.sv
rtl/asr_chk.sv
dv/tb_top.sv
